// ----- hw/rtl/bounded_ordered_list_engine_unit_assert.svh -----
// assertion macros for the bounded ordered list engine checker
// no dependencies; included by the checker file
`ifndef BOUNDED_ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

// clocked assertion, off while reset is applied
`define BOLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define BOLE_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/bole_pkg.sv -----
// shared types and constants of the bounded ordered list engine
// no dependencies; imported by the top level and the checker
`default_nettype none

package bole_pkg;

	// fixed field widths of the request and result words
	localparam int VAL_W  = 32;
	localparam int MODE_W = 3;
	localparam int POS_W  = 4;
	localparam int ENT_W  = 5;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request codes
	typedef enum logic [MODE_W-1:0] {
		MODE_PREPEND  = 3'd0,
		MODE_APPEND   = 3'd1,
		MODE_GET      = 3'd2,
		MODE_RMV_VAL  = 3'd3,
		MODE_RMV_POS  = 3'd4,
		MODE_CONTAINS = 3'd5
	} mode_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_LINK,
		ST_WALK,
		ST_UNLINK,
		ST_FREE
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bole_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module bole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/bole_link_store.sv -----
// next-slot link store: ram plus a fill mark that stands in for the reset free chain
// depends on bole_ram
`default_nettype none

module bole_link_store #(
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [AW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [AW-1:0] rdata
);

	logic [AW-1:0] ram_rdata;
	logic [AW-1:0] raddr_s1;
	logic [AW:0]   fill_q;
	logic [AW-1:0] fresh_link;

	bole_ram #(
		.WIDTH(AW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	// read address is registered alongside the ram read, so it lines up with the read data
	always_ff @(posedge clk) begin
		raddr_s1 <= raddr;
	end

	// slots are first written in ascending order, so a mark of how far
	// writing has got tells written slots from untouched ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (we && ({1'b0, waddr} == fill_q)) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// untouched slot still links to the next one, the last wraps to zero
	assign fresh_link = (raddr_s1 == AW'(DEPTH - 1)) ? '0 : raddr_s1 + AW'(1);
	assign rdata      = ({1'b0, raddr_s1} >= fill_q) ? fresh_link : ram_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_ordered_list_engine_unit.sv -----
// Bounded ordered list engine: linked list of values in a value ram and a link ram.
// Result strobe is registered: refused insert or unknown mode ends in idle, inserts in INS or
// LINK, get and contains at the end of the walk, removes in FREE (walk, UNLINK, FREE).
// One item at a time; the link walk takes one entry per cycle through the link ram read.
// Next word may start in the cycle its predecessor's result is shown. The receiver cannot stall.
// Async reset empties the list and sets capacity 16; no clearing pass is needed.
`default_nettype none

module bounded_ordered_list_engine_unit
	import bole_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [VAL_W-1:0]  item_value,
	input  wire logic [POS_W-1:0]  position,
	output logic                   done,
	output logic                   ok,
	output logic      [VAL_W-1:0]  value_out,
	output logic      [ENT_W-1:0]  entries,
	output logic                   is_full,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata
);

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int CMP_A  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int CMP_W  = (CMP_A > POS_W) ? CMP_A : POS_W;
	localparam logic [CMP_W-1:0] CAP_MAX = CMP_W'(CAPACITY);

	state_t state_q, state_d;

	// list registers
	logic [SLOT_W-1:0] head_q, tail_q, free_q;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CAP_W-1:0]  cap_q;

	// request and walk registers
	mode_t                 mode_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [POS_W-1:0]      pos_q;
	logic [SLOT_W-1:0]     cur_q, prev_q, next_q;
	logic [CNT_W-1:0]      idx_q;
	logic [VALUE_BITS-1:0] vout_q;

	// result registers
	logic             done_q, ok_q, full_q;
	logic [VAL_W-1:0] value_q;
	logic [ENT_W-1:0] ent_q;

	// memory ports
	logic [SLOT_W-1:0]     rd_addr;
	logic [VALUE_BITS-1:0] val_rd;
	logic [SLOT_W-1:0]     link_rd;
	logic                  lk_we, vs_we;
	logic [SLOT_W-1:0]     lk_waddr, lk_wdata;

	// decode and compare
	mode_t                 in_mode;
	logic                  accept, in_ins, in_walk, cap_reached, full_d;
	logic                  by_pos, is_rmv, in_range, hit;
	logic [CMP_W-1:0]      eff_cap;
	logic                  fin, res_ok;
	logic [VALUE_BITS-1:0] res_val;

	bole_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(CAPACITY)
	) u_value_ram (
		.clk  (clk),
		.we   (vs_we),
		.waddr(cur_q),
		.wdata(val_q),
		.raddr(rd_addr),
		.rdata(val_rd)
	);

	bole_link_store #(
		.DEPTH(CAPACITY)
	) u_link_store (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.raddr (rd_addr),
		.rdata (link_rd)
	);

	// request decode and list status
	assign in_mode     = mode_t'(mode);
	assign accept      = start && (state_q == ST_IDLE);
	assign in_ins      = (in_mode == MODE_PREPEND) || (in_mode == MODE_APPEND);
	assign in_walk     = (in_mode == MODE_GET) || (in_mode == MODE_RMV_VAL) ||
	                     (in_mode == MODE_RMV_POS) || (in_mode == MODE_CONTAINS);
	assign eff_cap     = (CMP_W'(cap_q) > CAP_MAX) ? CAP_MAX : CMP_W'(cap_q);
	assign cap_reached = CMP_W'(count_q) >= eff_cap;
	assign full_d      = CMP_W'(count_d) >= eff_cap;

	// walk match on the entry whose ram data is arriving
	assign by_pos   = (mode_q == MODE_GET) || (mode_q == MODE_RMV_POS);
	assign is_rmv   = (mode_q == MODE_RMV_VAL) || (mode_q == MODE_RMV_POS);
	assign in_range = idx_q < count_q;
	assign hit      = by_pos ? (CMP_W'(idx_q) == CMP_W'(pos_q)) : (val_rd == val_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_ins && !cap_reached) begin
						state_d = ST_INS;
					end else if (in_walk) begin
						state_d = ST_WALK;
					end
				end
			end
			ST_INS: begin
				state_d = ((mode_q == MODE_APPEND) && (count_q != '0)) ? ST_LINK : ST_IDLE;
			end
			ST_LINK: begin
				state_d = ST_IDLE;
			end
			ST_WALK: begin
				if (!in_range) begin
					state_d = ST_IDLE;
				end else if (hit) begin
					state_d = is_rmv ? ST_UNLINK : ST_IDLE;
				end
			end
			ST_UNLINK: begin
				state_d = ST_FREE;
			end
			ST_FREE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// memory controls, result and count update
	always_comb begin
		fin      = 1'b0;
		res_ok   = 1'b0;
		res_val  = '0;
		rd_addr  = cur_q;
		lk_we    = 1'b0;
		lk_waddr = cur_q;
		lk_wdata = next_q;
		vs_we    = 1'b0;
		count_d  = count_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rd_addr = in_ins ? free_q : head_q;
					fin     = !in_walk && !(in_ins && !cap_reached);
				end
			end
			ST_INS: begin
				vs_we    = 1'b1;
				lk_we    = 1'b1;
				lk_waddr = cur_q;
				lk_wdata = (mode_q == MODE_PREPEND) ? head_q : '0;
				count_d  = count_q + CNT_W'(1);
				fin      = !((mode_q == MODE_APPEND) && (count_q != '0));
				res_ok   = 1'b1;
			end
			ST_LINK: begin
				lk_we    = 1'b1;
				lk_waddr = tail_q;
				lk_wdata = cur_q;
				fin      = 1'b1;
				res_ok   = 1'b1;
			end
			ST_WALK: begin
				if (!in_range) begin
					fin = 1'b1;
				end else if (hit) begin
					if (!is_rmv) begin
						fin     = 1'b1;
						res_ok  = 1'b1;
						res_val = (mode_q == MODE_GET) ? val_rd : '0;
					end
				end else begin
					rd_addr = link_rd;
				end
			end
			ST_UNLINK: begin
				if (cur_q != head_q) begin
					lk_we    = 1'b1;
					lk_waddr = prev_q;
					lk_wdata = next_q;
				end
			end
			ST_FREE: begin
				lk_we    = 1'b1;
				lk_waddr = cur_q;
				lk_wdata = free_q;
				count_d  = count_q - CNT_W'(1);
				fin      = 1'b1;
				res_ok   = 1'b1;
				res_val  = vout_q;
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// control state: sequencer, list pointers, count, capacity, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			free_q  <= '0;
			count_q <= '0;
			cap_q   <= CAP_RESET;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= fin;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_INS: begin
					free_q <= link_rd;
					if (mode_q == MODE_PREPEND) begin
						head_q <= cur_q;
						if (count_q == '0) begin
							tail_q <= cur_q;
						end
					end else if (count_q == '0) begin
						head_q <= cur_q;
						tail_q <= cur_q;
					end
				end
				ST_LINK: begin
					tail_q <= cur_q;
				end
				ST_UNLINK: begin
					if (cur_q == head_q) begin
						if (count_q == CNT_W'(1)) begin
							head_q <= '0;
							tail_q <= '0;
						end else begin
							head_q <= next_q;
						end
					end else if (cur_q == tail_q) begin
						tail_q <= prev_q;
					end
				end
				ST_FREE: begin
					free_q <= cur_q;
				end
				default: begin
					free_q <= free_q;
				end
			endcase
		end
	end

	// request word, walk position and result word
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= in_mode;
			val_q  <= VALUE_BITS'(item_value);
			pos_q  <= position;
			cur_q  <= in_ins ? free_q : head_q;
			prev_q <= head_q;
			idx_q  <= '0;
		end
		if ((state_q == ST_WALK) && in_range) begin
			if (hit) begin
				next_q <= link_rd;
				vout_q <= val_rd;
			end else begin
				prev_q <= cur_q;
				cur_q  <= link_rd;
				idx_q  <= idx_q + CNT_W'(1);
			end
		end
		if (fin) begin
			ok_q    <= res_ok;
			value_q <= VAL_W'(res_val);
			ent_q   <= ENT_W'(count_d);
			full_q  <= full_d;
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign ok        = ok_q;
	assign value_out = value_q;
	assign entries   = ent_q;
	assign is_full   = full_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bole_check.sv -----
// port-level checker for the bounded ordered list engine, bound to the top level
// depends on bole_pkg and bounded_ordered_list_engine_unit_assert.svh
`default_nettype none

`include "bounded_ordered_list_engine_unit_assert.svh"

module bole_check
	import bole_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             done,
	input wire logic             ok,
	input wire logic [VAL_W-1:0] value_out
);

	// an accepted word either finishes at once or keeps the engine busy
	`BOLE_ASSERT(a_accept_progress, (start && !busy) |=> (busy || done), "accepted word dropped")

	// a result only follows an accepted word or a busy cycle
	`BOLE_ASSERT(a_done_has_cause, done |-> ($past(start && !busy) || $past(busy)), "stray result")

	// failed requests return no value
	`BOLE_ASSERT(a_fail_zero, (done && !ok) |-> (value_out == '0), "value on failed request")

	// reset leaves the engine idle with no result
	`BOLE_ASSERT_RST(a_reset_idle, !arst_n |-> (!busy && !done), "not idle in reset")

endmodule

bind bounded_ordered_list_engine_unit bole_check u_bole_check (.*);

`default_nettype wire
